[rtl/drum_step_sequencer_core_assert.svh]
// Assertion macros for the drum step sequencer core.
// Each macro samples on the rising edge of clk and is disabled during rst.
`ifndef DRUM_STEP_SEQUENCER_CORE_ASSERT_SVH
`define DRUM_STEP_SEQUENCER_CORE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset
`define DSS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Condition that must hold whenever the antecedent holds in the same cycle
`define DSS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/dss_pkg.sv]
`default_nettype none

package dss_pkg;

  localparam int STEPS      = 16;
  localparam int TRACKS     = 6;
  localparam int MEL_TRACKS = 3;
  localparam int BTN_W      = 24;

  // Mode codes
  localparam logic [1:0] MODE_PROGRAM   = 2'd0;
  localparam logic [1:0] MODE_PLAY      = 2'd1;
  localparam logic [1:0] MODE_WAIT_NOTE = 2'd2;

  // Button bits
  localparam int BTN_PREV = 0;
  localparam int BTN_NEXT = 1;
  localparam int BTN_PLAY = 7;

  // Track numbers
  localparam logic [2:0] TRK_KICK  = 3'd0;
  localparam logic [2:0] TRK_SNARE = 3'd1;
  localparam logic [2:0] TRK_HIHAT = 3'd2;
  localparam logic [2:0] TRK_TRI   = 3'd3;
  localparam logic [2:0] TRK_SQ1   = 3'd4;
  localparam logic [2:0] TRK_SQ2   = 3'd5;
  localparam logic [2:0] TRK_LAST  = 3'd5;

  // Sample trigger codes
  localparam logic [1:0] TRIG_NONE  = 2'd0;
  localparam logic [1:0] TRIG_KICK  = 2'd1;
  localparam logic [1:0] TRIG_SNARE = 2'd2;

  // Configuration register indexes
  localparam logic CFG_STEP_LENGTH  = 1'b0;
  localparam logic CFG_BLINK_PERIOD = 1'b1;

  localparam logic [7:0] STEP_LENGTH_RESET  = 8'd30;
  localparam logic [7:0] BLINK_PERIOD_RESET = 8'd60;
  localparam logic [7:0] BLINK_ENTRY_COUNT  = 8'd4;

  // One queued tick: rising edges of the button levels
  typedef struct packed {
    logic [BTN_W-1:0] rise;
  } item_t;

  typedef struct packed {
    logic [7:0] step_length;
    logic [7:0] blink_period;
  } cfg_t;

  typedef struct packed {
    logic       program_dot;
    logic [2:0] pattern_display;
    logic [15:0] step_leds;
    logic [9:0] triangle_period;
    logic [8:0] square2_period;
    logic [8:0] square1_period;
    logic       square2_gate;
    logic       square1_gate;
    logic       hihat_gate;
    logic [1:0] sample_trigger;
  } result_t;

  // Note periods C4 .. C5
  function automatic logic [7:0] note_period(input logic [2:0] idx);
    logic [7:0] v;
    unique case (idx)
      3'd0: v = 8'd197;
      3'd1: v = 8'd176;
      3'd2: v = 8'd156;
      3'd3: v = 8'd148;
      3'd4: v = 8'd131;
      3'd5: v = 8'd118;
      3'd6: v = 8'd104;
      3'd7: v = 8'd98;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/drum_step_sequencer_core.sv]
// Sixteen-step drum sequencer core.
// Input channel s_*: one transfer per main-loop tick, s_tdata carries the 24
// button levels (bit 0 prev, bit 1 next, bit 7 play, bits 8..23 steps).
// Output channel m_*: exactly one result transfer per input tick, in order,
// holding the sample trigger, gate levels, channel periods, step LEDs, track
// display and program dot.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 step_length, 1 blink_period); write only while the block is idle.
// Path: a tick is accepted into a two-entry queue, is read from the queue by
// the back end, and its result is registered in the output register that
// drives m_tvalid.
// Throughput: one tick per cycle while m_tready is high; the back end evaluates
// a whole tick (edge decode, pattern update and LED update) combinationally.
// Stalls: when m_tready is low the result is held; the queue absorbs two
// more ticks, then s_tready drops until the receiver takes the result.
// Reset: synchronous rst clears the nonzero flags of the pattern store, program
// mode, track 1, gates, periods and LEDs, and loads step_length 30 and blink_period 60.
`default_nettype none

module drum_step_sequencer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [23:0] buttons
  input  wire logic [23:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [1:0] sample_trigger, [2] hihat_gate, [3] square1_gate, [4] square2_gate,
  // [13:5] square1_period, [22:14] square2_period, [32:23] triangle_period,
  // [48:33] step_leds, [51:49] pattern_display, [52] program_dot, [55:53] zero
  output logic [55:0]      m_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  `include "drum_step_sequencer_core_assert.svh"

  dss_pkg::cfg_t    cfg;
  dss_pkg::item_t   push_item;
  dss_pkg::item_t   pop_item;
  dss_pkg::result_t result;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_length  <= dss_pkg::STEP_LENGTH_RESET;
      cfg.blink_period <= dss_pkg::BLINK_PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dss_pkg::CFG_STEP_LENGTH:  cfg.step_length  <= cfg_data;
        dss_pkg::CFG_BLINK_PERIOD: cfg.blink_period <= cfg_data;
        default: ;
      endcase
    end
  end

  dss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  dss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .pop_item  (pop_item)
  );

  dss_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .item       (pop_item),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result)
  );

  // Pack the result, zero fill to whole bytes
  assign m_tdata = {3'b000, result};

  `DSS_ASSERT_IMPLY(a_display_range, m_tvalid, result.pattern_display != 3'd0 && result.pattern_display != 3'd7, "track display out of range")
  `DSS_ASSERT_ALWAYS(a_trigger_code, !m_tvalid || result.sample_trigger != 2'd3, "illegal sample trigger code")
  `DSS_ASSERT_IMPLY(a_trigger_play, m_tvalid && result.sample_trigger != dss_pkg::TRIG_NONE, !result.program_dot, "sample fired outside play")
  `DSS_ASSERT_IMPLY(a_gates_play, m_tvalid && result.program_dot, !result.hihat_gate && !result.square1_gate && !result.square2_gate && result.triangle_period == 10'd0, "channel sounding in program mode")

endmodule

`default_nettype wire

[rtl/dss_front.sv]
`default_nettype none

module dss_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [dss_pkg::BTN_W-1:0] s_tdata,
  input  wire logic                      q_full,
  output logic                           push,
  output dss_pkg::item_t                 push_item
);

  logic [dss_pkg::BTN_W-1:0] prev_buttons;

  // Take a tick whenever the queue has room
  assign s_tready       = !q_full;
  assign push           = s_tvalid && s_tready;
  assign push_item.rise = s_tdata & ~prev_buttons;

  // Hold the levels of the last accepted tick for edge detection
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_buttons <= '0;
    end else if (push) begin
      prev_buttons <= s_tdata;
    end
  end

endmodule

`default_nettype wire

[rtl/dss_queue.sv]
`default_nettype none

module dss_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire dss_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output logic                q_valid,
  output dss_pkg::item_t      pop_item
);

  dss_pkg::item_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full     = (count == 2'd2);
  assign q_valid  = (count != 2'd0);
  assign pop_item = mem[rd_ptr];

  // Store incoming ticks
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= 2'(count + 2'd1);
      else if (pop && !push) count <= 2'(count - 2'd1);
    end
  end

endmodule

`default_nettype wire

[rtl/dss_back.sv]
`default_nettype none

module dss_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dss_pkg::cfg_t   cfg,
  input  wire logic            q_valid,
  input  wire dss_pkg::item_t  item,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output dss_pkg::result_t     out_result
);

  // Sequencer state
  logic [1:0]  mode, mode_next;
  logic [2:0]  sel, sel_next;
  logic [3:0]  pos, pos_next;
  logic [7:0]  tc, tc_next;
  logic [2:0]  gates, gates_next;
  logic [8:0]  sq1p, sq1p_next;
  logic [8:0]  sq2p, sq2p_next;
  logic [9:0]  tri_lvl, tri_lvl_next;
  logic [15:0] latch, latch_next;
  logic [1:0]  trig;

  // Pattern store: nonzero flag per track and step, note index for melodic tracks
  logic [dss_pkg::TRACKS-1:0][dss_pkg::STEPS-1:0]              nz, nz_next;
  logic [dss_pkg::MEL_TRACKS-1:0][dss_pkg::STEPS-1:0][2:0]     notes, notes_next;

  logic [dss_pkg::STEPS-1:0] step_rise;
  logic                      pick_any;
  logic [3:0]                pick_step;
  logic                      note_any;
  logic [2:0]                note_pick;
  logic [1:0]                mel_sel;
  logic [7:0]                cnt;
  logic [15:0]               onehot;

  // Process a queued tick when the output register is free or draining
  assign pop = q_valid && (!out_valid || out_ready);

  assign step_rise = {item.rise[15:8], item.rise[23:16]};
  assign mel_sel   = 2'(sel - dss_pkg::TRK_TRI);

  // Step button on the lowest button bit opens note entry, highest note button wins
  always_comb begin
    pick_any  = 1'b0;
    pick_step = '0;
    note_any  = 1'b0;
    note_pick = '0;
    for (int i = 23; i >= 8; i--) begin
      if (item.rise[i]) begin
        pick_any  = 1'b1;
        pick_step = (i < 16) ? 4'(i) : 4'(i - 16);
      end
    end
    for (int i = 0; i < 8; i++) begin
      if (item.rise[i]) begin
        note_any  = 1'b1;
        note_pick = 3'(i);
      end
    end
  end

  // Task step followed by LED step
  always_comb begin
    mode_next    = mode;
    sel_next     = sel;
    pos_next     = pos;
    tc_next      = tc;
    gates_next   = gates;
    sq1p_next    = sq1p;
    sq2p_next    = sq2p;
    tri_lvl_next = tri_lvl;
    latch_next   = latch;
    nz_next      = nz;
    notes_next   = notes;
    trig         = dss_pkg::TRIG_NONE;
    cnt          = tc;
    onehot       = '0;

    priority if (item.rise[dss_pkg::BTN_PLAY]) begin
      unique case (mode)
        dss_pkg::MODE_WAIT_NOTE: begin
          nz_next[sel][pos] = 1'b0;
          mode_next         = dss_pkg::MODE_PROGRAM;
        end
        dss_pkg::MODE_PROGRAM: begin
          mode_next = dss_pkg::MODE_PLAY;
          pos_next  = '0;
          tc_next   = cfg.step_length;
        end
        dss_pkg::MODE_PLAY: begin
          mode_next    = dss_pkg::MODE_PROGRAM;
          gates_next   = '0;
          tri_lvl_next = '0;
        end
        default: ;
      endcase
    end else if (mode == dss_pkg::MODE_WAIT_NOTE) begin
      if (note_any) begin
        nz_next[sel][pos]        = 1'b1;
        notes_next[mel_sel][pos] = note_pick;
        mode_next                = dss_pkg::MODE_PROGRAM;
      end
    end else if (mode == dss_pkg::MODE_PROGRAM) begin
      priority if (item.rise[dss_pkg::BTN_NEXT] && sel < dss_pkg::TRK_LAST) begin
        sel_next = 3'(sel + 3'd1);
      end else if (item.rise[dss_pkg::BTN_PREV] && sel > dss_pkg::TRK_KICK) begin
        sel_next = 3'(sel - 3'd1);
      end else begin
        sel_next = sel;
      end
      if (sel_next < dss_pkg::TRK_TRI) begin
        nz_next[sel_next] = nz[sel_next] ^ step_rise;
      end else if (pick_any) begin
        mode_next = dss_pkg::MODE_WAIT_NOTE;
        pos_next  = pick_step;
        tc_next   = dss_pkg::BLINK_ENTRY_COUNT;
      end
    end else if (mode == dss_pkg::MODE_PLAY) begin
      if (tc == (cfg.step_length >> 1)) begin
        gates_next   = '0;
        tri_lvl_next = '0;
      end
      tc_next = 8'(tc - 8'd1);
      if (tc == 8'd0) begin
        tc_next = cfg.step_length;
        if (nz[dss_pkg::TRK_KICK][pos])  trig = dss_pkg::TRIG_KICK;
        if (nz[dss_pkg::TRK_SNARE][pos]) trig = dss_pkg::TRIG_SNARE;
        if (nz[dss_pkg::TRK_HIHAT][pos]) gates_next[2] = 1'b1;
        tri_lvl_next = nz[dss_pkg::TRK_TRI][pos]
                     ? {dss_pkg::note_period(notes[0][pos]), 2'b00} : 10'd0;
        if (nz[dss_pkg::TRK_SQ1][pos]) begin
          gates_next[0] = 1'b1;
          sq1p_next     = {dss_pkg::note_period(notes[1][pos]), 1'b0};
        end
        if (nz[dss_pkg::TRK_SQ2][pos]) begin
          gates_next[1] = 1'b1;
          sq2p_next     = {dss_pkg::note_period(notes[2][pos]), 1'b0};
        end
        pos_next = 4'(pos + 4'd1);
      end
    end else begin
      // unused mode code: hold the sequencer state
      mode_next = mode;
    end

    // LED step on the updated state
    onehot = 16'd1 << pos_next;
    if (mode_next == dss_pkg::MODE_WAIT_NOTE) begin
      cnt = 8'(tc_next - 8'd1);
      if (cnt == 8'd0) begin
        cnt = cfg.blink_period;
        if (!pos_next[3]) latch_next = {latch_next[15:8], onehot[7:0]};
        else              latch_next = {onehot[15:8], latch_next[7:0]};
      end
      if (cnt == (cfg.blink_period >> 1)) latch_next = '0;
      tc_next = cnt;
    end else if (mode_next == dss_pkg::MODE_PROGRAM) begin
      latch_next = nz_next[sel_next];
    end else if (mode_next == dss_pkg::MODE_PLAY) begin
      latch_next = onehot;
    end
  end

  // Commit state on each processed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= dss_pkg::MODE_PROGRAM;
      sel     <= dss_pkg::TRK_KICK;
      pos     <= '0;
      tc      <= '0;
      gates   <= '0;
      sq1p    <= '0;
      sq2p    <= '0;
      tri_lvl <= '0;
      latch   <= '0;
      nz      <= '0;
    end else if (pop) begin
      mode    <= mode_next;
      sel     <= sel_next;
      pos     <= pos_next;
      tc      <= tc_next;
      gates   <= gates_next;
      sq1p    <= sq1p_next;
      sq2p    <= sq2p_next;
      tri_lvl <= tri_lvl_next;
      latch   <= latch_next;
      nz      <= nz_next;
    end
  end

  // Note indexes are qualified by the nonzero flags
  always_ff @(posedge clk) begin
    if (pop) begin
      notes <= notes_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_result.sample_trigger  <= trig;
      out_result.hihat_gate      <= gates_next[2];
      out_result.square1_gate    <= gates_next[0];
      out_result.square2_gate    <= gates_next[1];
      out_result.square1_period  <= sq1p_next;
      out_result.square2_period  <= sq2p_next;
      out_result.triangle_period <= tri_lvl_next;
      out_result.step_leds       <= latch_next;
      out_result.pattern_display <= 3'(sel_next + 3'd1);
      out_result.program_dot     <= (mode_next == dss_pkg::MODE_PROGRAM);
    end
  end

endmodule

`default_nettype wire
